>>> design/binary_trie_max_xor_macros.svh
// assertion macros for the binary trie max-xor block
// expects clk and arst_n in the scope of the module that uses them
`ifndef BINARY_TRIE_MAX_XOR_MACROS_SVH
`define BINARY_TRIE_MAX_XOR_MACROS_SVH

// property checked at every clock edge outside reset
`define BTMX_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition in one cycle implies expression in the next
`define BTMX_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

>>> design/btmx_pkg.sv
// shared types and constants for the binary trie max-xor block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package btmx_pkg;

	localparam int NODE_COUNT = 4096;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_W    = 32;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int USED_W     = NODE_W + 1;
	localparam int LVL_W      = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

	typedef logic [NODE_W-1:0] node_idx_t;
	typedef logic [1:0][NODE_W-1:0] link_pair_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_QUERY  = 1'b1
	} func_t;

	typedef struct packed {
		logic      en;
		node_idx_t addr;
	} rd_req_t;

	typedef struct packed {
		logic       en;
		node_idx_t  addr;
		link_pair_t data;
	} wr_req_t;

endpackage

`default_nettype wire

>>> design/btmx_in_if.sv
// request channel: operation and key
// depends on btmx_pkg
`timescale 1ns / 1ps
`default_nettype none

interface btmx_in_if;
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic [btmx_pkg::VALUE_W-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

`default_nettype wire

>>> design/btmx_out_if.sv
// result channel: max xor and status
// depends on btmx_pkg
`timescale 1ns / 1ps
`default_nettype none

interface btmx_out_if;
	logic                         valid;
	logic                         ready;
	logic [btmx_pkg::VALUE_W-1:0] max_xor;
	logic [1:0]                   status;

	modport source (output valid, output max_xor, output status, input ready);
	modport sink (input valid, input max_xor, input status, output ready);
endinterface

`default_nettype wire

>>> design/btmx_node_store.sv
// trie node store: root links in flops, other nodes in a synchronous memory
// depends on btmx_pkg
`timescale 1ns / 1ps
`default_nettype none

module btmx_node_store (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire btmx_pkg::rd_req_t    rd,
	input  wire btmx_pkg::wr_req_t    wr,
	output btmx_pkg::link_pair_t      rd_links
);

	btmx_pkg::link_pair_t mem [btmx_pkg::NODE_COUNT];
	btmx_pkg::link_pair_t mem_rd_q;
	btmx_pkg::link_pair_t root_q;
	logic                 rd_root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q    <= '0;
			rd_root_q <= 1'b0;
		end else begin
			if (wr.en && (wr.addr == '0)) begin
				root_q <= wr.data;
			end
			if (rd.en) begin
				rd_root_q <= (rd.addr == '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && (wr.addr != '0)) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			mem_rd_q <= mem[rd.addr];
		end
	end

	assign rd_links = rd_root_q ? root_q : mem_rd_q;

endmodule

`default_nettype wire

>>> design/binary_trie_max_xor.sv
// top level of the binary trie max-xor block: handshake, trie walk, node allocation
// depends on btmx_pkg, btmx_in_if, btmx_out_if, btmx_node_store and the macro header
`timescale 1ns / 1ps
`default_nettype none
`include "binary_trie_max_xor_macros.svh"

// Keeps a binary trie of 32-bit keys in a 4096-node store and answers two
// operations: insert a key, or query the largest xor of a key with any stored
// key. Every request gives exactly one result. An insert or query walks the trie
// one level per cycle through the node memory (registered read, the address of
// the next node formed from the data of the current one), then waits in the
// done state until the output register is free and moves its result there. A
// query on an empty trie and an insert refused because fewer than 32 nodes are
// free skip the walk and go straight to the done state. A new request is
// accepted as soon as the previous one has moved its result into the output
// register, even while that result still waits.
// The root node sits in flops and is cleared by reset; no clearing pass runs.
module binary_trie_max_xor (
	input wire        clk,
	input wire        arst_n,
	btmx_in_if.sink   req,
	btmx_out_if.source rsp
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                       state_q;
	logic [btmx_pkg::KEY_BITS-1:0] key_q;
	logic                          func_q;
	logic [btmx_pkg::LVL_W-1:0]    lvl_q;
	logic                          fresh_q;
	btmx_pkg::node_idx_t           cur_q;
	logic [btmx_pkg::KEY_BITS-1:0] res_q;
	btmx_pkg::status_t             st_q;
	logic [btmx_pkg::USED_W-1:0]   used_q;
	logic                          has_keys_q;
	logic                          out_vld_q;
	logic [btmx_pkg::VALUE_W-1:0]  out_mx_q;
	btmx_pkg::status_t             out_st_q;

	btmx_pkg::rd_req_t    rd;
	btmx_pkg::wr_req_t    wr;
	btmx_pkg::link_pair_t rd_links;
	btmx_pkg::link_pair_t links;
	btmx_pkg::link_pair_t upd_links;

	logic                in_acc;
	logic                full;
	logic                empty;
	logic                bit_k;
	logic                hit;
	logic                take;
	logic                miss;
	btmx_pkg::node_idx_t alloc;
	btmx_pkg::node_idx_t nxt;
	logic                out_free;

	btmx_node_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd       (rd),
		.wr       (wr),
		.rd_links (rd_links)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign in_acc    = req.valid && req.ready;
	assign full      = (used_q > btmx_pkg::USED_W'(btmx_pkg::NODE_COUNT - btmx_pkg::KEY_BITS));
	assign empty     = !has_keys_q;
	assign out_free  = !out_vld_q || rsp.ready;

	assign links = fresh_q ? '0 : rd_links;
	assign bit_k = key_q[lvl_q];
	assign hit   = (links[!bit_k] != '0);
	assign take  = hit ? !bit_k : bit_k;
	assign alloc = used_q[btmx_pkg::NODE_W-1:0];
	assign miss  = (links[bit_k] == '0);

	always_comb begin
		upd_links        = links;
		upd_links[bit_k] = alloc;
		if (func_q == btmx_pkg::FUNC_QUERY) begin
			nxt = links[take];
		end else if (miss) begin
			nxt = alloc;
		end else begin
			nxt = links[bit_k];
		end
	end

	always_comb begin
		rd = '0;
		wr = '0;
		if (in_acc) begin
			rd.en   = 1'b1;
			rd.addr = '0;
		end else if (state_q == ST_WALK) begin
			rd.en   = 1'b1;
			rd.addr = nxt;
			if ((func_q == btmx_pkg::FUNC_INSERT) && miss) begin
				wr.en   = 1'b1;
				wr.addr = cur_q;
				wr.data = upd_links;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			used_q     <= btmx_pkg::USED_W'(1);
			has_keys_q <= 1'b0;
			out_vld_q  <= 1'b0;
			fresh_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						fresh_q <= 1'b0;
						if ((req.func == btmx_pkg::FUNC_INSERT) ? full : empty) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if ((func_q == btmx_pkg::FUNC_INSERT) && miss) begin
						used_q  <= used_q + btmx_pkg::USED_W'(1);
						fresh_q <= 1'b1;
					end
					if (lvl_q == '0) begin
						state_q <= ST_DONE;
						if (func_q == btmx_pkg::FUNC_INSERT) begin
							has_keys_q <= 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (state_q == ST_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q  <= req.value[btmx_pkg::KEY_BITS-1:0];
			func_q <= req.func;
			lvl_q  <= btmx_pkg::LVL_W'(btmx_pkg::KEY_BITS - 1);
			cur_q  <= '0;
			res_q  <= '0;
			if (req.func == btmx_pkg::FUNC_INSERT) begin
				st_q <= full ? btmx_pkg::STATUS_FULL : btmx_pkg::STATUS_OK;
			end else begin
				st_q <= empty ? btmx_pkg::STATUS_EMPTY : btmx_pkg::STATUS_OK;
			end
		end else if (state_q == ST_WALK) begin
			lvl_q <= lvl_q - btmx_pkg::LVL_W'(1);
			cur_q <= nxt;
			if (func_q == btmx_pkg::FUNC_QUERY) begin
				res_q <= (res_q << 1) | btmx_pkg::KEY_BITS'(hit);
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_mx_q <= btmx_pkg::VALUE_W'(res_q);
			out_st_q <= st_q;
		end
	end

	assign rsp.valid   = out_vld_q;
	assign rsp.max_xor = out_mx_q;
	assign rsp.status  = out_st_q;

	`BTMX_ASSERT(a_used_bound, (used_q <= btmx_pkg::USED_W'(btmx_pkg::NODE_COUNT)), "node count overflow")
	`BTMX_ASSERT(a_wr_rd_apart, (!wr.en || (wr.addr != rd.addr)), "write and read hit the same node")
	`BTMX_ASSERT(a_query_no_write, (!wr.en || (func_q == btmx_pkg::FUNC_INSERT)), "query wrote the store")
	`BTMX_ASSERT_NEXT(a_walk_to_done, (state_q == ST_WALK) && (lvl_q == '0), (state_q == ST_DONE), "walk did not finish")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// self-checking bench for binary_trie_max_xor: random and directed inserts and queries
// keeps its own trie to predict max xor and status; depends on btmx_pkg and both channel interfaces
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_CMDS = 700;

	typedef struct {
		btmx_pkg::func_t op;
		logic [31:0]     key;
		bit              drain;
	} cmd_t;

	typedef struct {
		logic [31:0]       max_xor;
		btmx_pkg::status_t status;
	} reply_t;

	logic clk;
	logic arst_n = 1'b0;

	btmx_in_if  req_if();
	btmx_out_if rsp_if();

	binary_trie_max_xor uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	cmd_t        cmd_q[$];
	reply_t      reply_q[$];
	logic [31:0] gen_keys[$];

	btmx_pkg::node_idx_t trie_link[btmx_pkg::NODE_COUNT][2];
	int unsigned         trie_used;
	bit                  trie_has_keys;

	int  n_acc = 0;
	int  n_rcv = 0;
	int  errors = 0;
	int  cycles = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	bit  tail = 1'b0;

	always #5 clk = ~clk;

	// walks the trie model and returns the reply for one transaction
	function automatic reply_t trie_apply(input btmx_pkg::func_t op, input logic [31:0] raw);
		reply_t              r;
		logic [31:0]         mask;
		logic [31:0]         key;
		logic [31:0]         best;
		btmx_pkg::node_idx_t node;
		btmx_pkg::node_idx_t nxt;
		logic                b;
		logic                take;
		mask = 32'((64'd1 << btmx_pkg::KEY_BITS) - 1);
		key = raw & mask;
		r.max_xor = '0;
		r.status = btmx_pkg::STATUS_OK;
		node = '0;
		best = '0;
		if (op == btmx_pkg::FUNC_INSERT) begin
			if (btmx_pkg::NODE_COUNT - trie_used < btmx_pkg::KEY_BITS) begin
				r.status = btmx_pkg::STATUS_FULL;
			end else begin
				for (int lvl = btmx_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
					b = key[lvl];
					nxt = trie_link[node][b];
					if (nxt == '0) begin
						nxt = btmx_pkg::node_idx_t'(trie_used);
						trie_link[nxt][0] = '0;
						trie_link[nxt][1] = '0;
						trie_link[node][b] = nxt;
						trie_used++;
					end
					node = nxt;
				end
				trie_has_keys = 1'b1;
			end
		end else if (!trie_has_keys) begin
			r.status = btmx_pkg::STATUS_EMPTY;
		end else begin
			for (int lvl = btmx_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
				b = key[lvl];
				take = (trie_link[node][~b] != '0) ? ~b : b;
				best[lvl] = take;
				node = trie_link[node][take];
			end
			r.max_xor = (best ^ key) & mask;
		end
		return r;
	endfunction

	function automatic logic [31:0] pick_stored();
		if (gen_keys.size() == 0)
			return $urandom;
		return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
	endfunction

	function automatic logic [31:0] near_key(input logic [31:0] k);
		logic [31:0] low;
		low = 32'hFFFFFFFF >> $urandom_range(1, 31);
		return k ^ ($urandom & low);
	endfunction

	task automatic add_cmd(input btmx_pkg::func_t op, input logic [31:0] key, input bit drain);
		cmd_t c;
		c.op = op;
		c.key = key;
		c.drain = drain;
		cmd_q = {cmd_q, c};
		if (op == btmx_pkg::FUNC_INSERT)
			gen_keys = {gen_keys, key};
	endtask

	// driver: presents queued transactions, predicts each one when accepted
	always @(posedge clk) begin
		bit     fired;
		cmd_t   c;
		reply_t r;
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.func <= btmx_pkg::FUNC_INSERT;
			req_if.value <= '0;
		end else begin
			fired = req_if.valid && req_if.ready;
			if (fired) begin
				r = trie_apply(btmx_pkg::func_t'(req_if.func), req_if.value);
				reply_q = {reply_q, r};
				n_acc <= n_acc + 1;
			end
			tail <= (cmd_q.size() < 60);
			if (!req_if.valid || fired) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req_if.valid <= 1'b0;
				end else if (cmd_q.size() == 0) begin
					req_if.valid <= 1'b0;
				end else if (cmd_q[0].drain && n_rcv != n_acc + int'(fired)) begin
					req_if.valid <= 1'b0;
				end else if (!tail && (cmd_q.size() % 160) > 40 &&
						$urandom_range(0, 6) == 0) begin
					gap_left <= $urandom_range(0, 18);
					req_if.valid <= 1'b0;
				end else begin
					c = cmd_q.pop_front();
					req_if.valid <= 1'b1;
					req_if.func <= c.op;
					req_if.value <= c.key;
				end
			end
		end
	end

	// monitor: checks each result transaction against the oldest prediction
	always @(posedge clk) begin
		reply_t e;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (n_rcv >= n_acc) begin
					$error("result with no transaction pending: max_xor %h status %0d",
						rsp_if.max_xor, rsp_if.status);
					errors++;
				end else begin
					e = reply_q.pop_front();
					if (rsp_if.max_xor !== e.max_xor) begin
						$error("max_xor: expected %h, got %h", e.max_xor, rsp_if.max_xor);
						errors++;
					end
					if (rsp_if.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, rsp_if.status);
						errors++;
					end
					n_rcv <= n_rcv + 1;
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				rsp_if.ready <= 1'b0;
			end else if (!tail && (cycles % 3000) > 700 && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 18);
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		logic [31:0]     k;
		int              pick;
		btmx_pkg::func_t op;
		clk = 1'b0;
		trie_used = 1;
		trie_has_keys = 1'b0;
		trie_link[0][0] = '0;
		trie_link[0][1] = '0;

		// empty trie, extremes, duplicates, alternating patterns
		add_cmd(btmx_pkg::FUNC_QUERY, 32'h00000000, 1'b0);
		add_cmd(btmx_pkg::FUNC_QUERY, 32'hFFFFFFFF, 1'b0);
		add_cmd(btmx_pkg::FUNC_INSERT, 32'h00000000, 1'b0);
		add_cmd(btmx_pkg::FUNC_QUERY, 32'h00000000, 1'b0);
		add_cmd(btmx_pkg::FUNC_QUERY, 32'hFFFFFFFF, 1'b0);
		add_cmd(btmx_pkg::FUNC_INSERT, 32'hFFFFFFFF, 1'b0);
		add_cmd(btmx_pkg::FUNC_QUERY, 32'h00000000, 1'b0);
		add_cmd(btmx_pkg::FUNC_QUERY, 32'h0000FFFF, 1'b0);
		add_cmd(btmx_pkg::FUNC_INSERT, 32'h00000000, 1'b0);
		add_cmd(btmx_pkg::FUNC_INSERT, 32'h80000000, 1'b1);
		add_cmd(btmx_pkg::FUNC_INSERT, 32'h7FFFFFFF, 1'b0);
		add_cmd(btmx_pkg::FUNC_INSERT, 32'h55555555, 1'b0);
		add_cmd(btmx_pkg::FUNC_INSERT, 32'hAAAAAAAA, 1'b0);
		add_cmd(btmx_pkg::FUNC_QUERY, 32'h55555555, 1'b0);
		add_cmd(btmx_pkg::FUNC_QUERY, 32'hAAAAAAAA, 1'b0);
		add_cmd(btmx_pkg::FUNC_QUERY, 32'h00000001, 1'b0);
		add_cmd(btmx_pkg::FUNC_QUERY, 32'h80000000, 1'b0);
		add_cmd(btmx_pkg::FUNC_QUERY, 32'h7FFFFFFE, 1'b0);
		add_cmd(btmx_pkg::FUNC_INSERT, 32'h00000001, 1'b0);
		add_cmd(btmx_pkg::FUNC_QUERY, 32'hFFFFFFFE, 1'b1);

		// random mix; plain random inserts eventually fill the node store
		for (int i = 0; i < RANDOM_CMDS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 27)
				k = $urandom;
			else if (pick < 36)
				k = near_key(pick_stored());
			else if (pick < 45)
				k = pick_stored();
			else if (pick < 60)
				k = $urandom;
			else if (pick < 72)
				k = pick_stored();
			else if (pick < 82)
				k = ~pick_stored();
			else
				k = near_key(pick_stored());
			if (pick < 45)
				op = btmx_pkg::FUNC_INSERT;
			else
				op = btmx_pkg::FUNC_QUERY;
			add_cmd(op, k, (i % 233) == 100);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (cmd_q.size() != 0 || req_if.valid || n_rcv != n_acc);
		repeat (60) @(posedge clk);

		if (errors == 0 && reply_q.size() == 0 && n_rcv == n_acc) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
